// ----- src/prbp_pkg.sv -----
// Shared types and constants for the pin-and-ring budget planner.
// No dependencies; imported by every module of the block.
package prbp_pkg;

   localparam int MAX_LAYERS = 1024;
   localparam int MAX_PASSES = 4;

   localparam int SIZE_W   = 40;
   localparam int BUDGET_W = 48;
   localparam int RING_W   = 7;
   localparam int IDX_W    = $clog2(MAX_LAYERS);
   localparam int CNT_W    = $clog2(MAX_LAYERS + 1);
   localparam int PASS_W   = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
   localparam int RSV_W    = SIZE_W + RING_W;
   localparam int SUM_W    = BUDGET_W + 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0]   EMPTY_SLOT = SIZE_W'(4096);
   localparam logic [RING_W-1:0]   MIN_RING   = RING_W'(2);
   localparam logic [PASS_W-1:0]   LAST_PASS  = PASS_W'(MAX_PASSES - 1);
   localparam logic [CNT_W-1:0]    FULL_COUNT = CNT_W'(MAX_LAYERS);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING   = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] layer_bytes;
      logic              is_last;
   } req_word_type;

   typedef struct packed {
      logic [CNT_W-1:0]  pinned_count;
      logic [SIZE_W-1:0] slot_bytes;
   } rsp_word_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
      logic             out_free;
   } plan_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [CNT_W-1:0]  pinned;
      logic [SIZE_W-1:0] slot;
   } plan_res_type;

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_INIT,
      PS_RESERVE,
      PS_AVAIL,
      PS_SCAN,
      PS_DECIDE,
      PS_DONE
   } plan_state_type;

endpackage

// ----- src/prbp_layer_mem.sv -----
// Layer size store: one write port, one registered read port.
// Depends on prbp_pkg.
module prbp_layer_mem
   import prbp_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [SIZE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [SIZE_W-1:0] rd_data
);

   logic [SIZE_W-1:0] mem_ff [MAX_LAYERS];
   logic [SIZE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/prbp_planner.sv -----
// Plan sequencer: walks the layer store once for the initial slot and once
// per pass, sharing one multiplier, one subtract and one add/compare.
// Depends on prbp_pkg.
module prbp_planner
   import prbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  plan_ctl_type        ctl,
   input  logic [BUDGET_W-1:0] budget,
   input  logic [RING_W-1:0]   ring,
   input  logic [SIZE_W-1:0]   rd_data,
   output logic                rd_en,
   output logic [IDX_W-1:0]    rd_addr,
   output plan_res_type        res
);

   plan_state_type state_ff, state_in;

   logic                dv_ff, dv_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic [SIZE_W-1:0]   max_ff, max_in;
   logic [SIZE_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    npin_ff, npin_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic [RSV_W-1:0]    reserve_ff, reserve_in;
   logic [BUDGET_W-1:0] avail_ff, avail_in;
   logic [BUDGET_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                pinning_ff, pinning_in;

   logic                walk_end;
   logic [SIZE_W-1:0]   need;
   logic [RING_W-1:0]   ring_eff;
   logic [SUM_W-1:0]    sum;
   logic                fits;
   logic                settled;
   logic [BUDGET_W-1:0] reserve_ext;

   assign walk_end    = (issue_ff == count_ff) && !dv_ff;
   assign need        = (max_ff == '0) ? EMPTY_SLOT : max_ff;
   assign ring_eff    = (ring < MIN_RING) ? MIN_RING : ring;
   assign sum         = {1'b0, used_ff} + SUM_W'(rd_data);
   assign fits        = sum <= {1'b0, avail_ff};
   assign settled     = (n_ff == npin_ff) && (need == slot_ff);
   assign reserve_ext = BUDGET_W'(reserve_ff);
   assign rd_addr     = issue_ff[IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PS_IDLE:    if (ctl.start) state_in = PS_INIT;
         PS_INIT:    if (walk_end) state_in = PS_RESERVE;
         PS_RESERVE: state_in = PS_AVAIL;
         PS_AVAIL:   state_in = PS_SCAN;
         PS_SCAN:    if (walk_end) state_in = PS_DECIDE;
         PS_DECIDE: begin
            if (settled || pass_ff == LAST_PASS) begin
               state_in = PS_DONE;
            end else begin
               state_in = PS_RESERVE;
            end
         end
         PS_DONE:    if (ctl.out_free) state_in = PS_IDLE;
         default:    state_in = PS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rd_en      = 1'b0;
      res.busy   = 1'b1;
      res.done   = 1'b0;
      res.pinned = npin_ff;
      res.slot   = slot_ff;
      case (state_ff)
         PS_IDLE:          res.busy = 1'b0;
         PS_INIT, PS_SCAN: rd_en = (issue_ff != count_ff);
         PS_DONE:          res.done = ctl.out_free;
         default:          ;
      endcase
   end

   // datapath
   always_comb begin
      dv_in      = rd_en;
      count_in   = count_ff;
      issue_in   = issue_ff + CNT_W'(rd_en);
      max_in     = max_ff;
      slot_in    = slot_ff;
      npin_in    = npin_ff;
      pass_in    = pass_ff;
      reserve_in = reserve_ff;
      avail_in   = avail_ff;
      used_in    = used_ff;
      n_in       = n_ff;
      pinning_in = pinning_ff;
      case (state_ff)
         PS_IDLE: begin
            count_in = ctl.count;
            issue_in = '0;
            max_in   = '0;
         end
         PS_INIT: begin
            if (dv_ff && rd_data > max_ff) max_in = rd_data;
            if (walk_end) begin
               slot_in = need;
               npin_in = '0;
               pass_in = '0;
            end
         end
         PS_RESERVE: begin
            reserve_in = RSV_W'(slot_ff) * RSV_W'(ring_eff);
         end
         PS_AVAIL: begin
            avail_in   = (budget > reserve_ext) ? budget - reserve_ext : '0;
            used_in    = '0;
            n_in       = '0;
            pinning_in = 1'b1;
            max_in     = '0;
            issue_in   = '0;
         end
         PS_SCAN: begin
            if (dv_ff) begin
               // pinning stops at the first layer that does not fit;
               // everything from there on counts toward the slot
               if (pinning_ff && fits) begin
                  used_in = sum[BUDGET_W-1:0];
                  n_in    = n_ff + 1'b1;
               end else begin
                  pinning_in = 1'b0;
                  if (rd_data > max_ff) max_in = rd_data;
               end
            end
         end
         PS_DECIDE: begin
            if (!settled) begin
               npin_in = n_ff;
               slot_in = need;
               pass_in = pass_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_IDLE;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      issue_ff   <= issue_in;
      max_ff     <= max_in;
      slot_ff    <= slot_in;
      npin_ff    <= npin_in;
      pass_ff    <= pass_in;
      reserve_ff <= reserve_in;
      avail_ff   <= avail_in;
      used_ff    <= used_in;
      n_ff       <= n_in;
      pinning_ff <= pinning_in;
   end

endmodule

// ----- src/pin_and_ring_budget_planner_core.sv -----
// Pin-and-ring budget planner, top level.
// Words that are not last are taken one per cycle while req_stall is low, and stored while the store has room.
// A last word starts a plan for N stored layers and P passes (1 to 4); input stays stalled while the
// plan runs and until its result word is issued, so result stalls hold the input off as well.
// Reset is synchronous: budget clears to 0, ring count to 2; store undefined.
// Depends on prbp_pkg, prbp_layer_mem and prbp_planner.
module pin_and_ring_budget_planner_core
   import prbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BUDGET_W-1:0]  csr_data
);

   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [RING_W-1:0]   ring_ff, ring_in;
   logic [CNT_W-1:0]    layer_count_ff, layer_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                req_accept;
   logic                store_full;
   logic                wr_en;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [SIZE_W-1:0]   rd_data;
   plan_ctl_type        ctl;
   plan_res_type        res;

   assign req_stall  = res.busy;
   assign req_accept = req_valid && !req_stall;
   assign store_full = (layer_count_ff == FULL_COUNT);
   assign wr_en      = req_accept && !store_full;

   assign ctl.start    = req_accept && req_word.is_last;
   assign ctl.count    = store_full ? layer_count_ff : layer_count_ff + 1'b1;
   assign ctl.out_free = !rsp_valid_ff || !rsp_stall;

   prbp_layer_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (layer_count_ff[IDX_W-1:0]),
      .wr_data (req_word.layer_bytes),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   prbp_planner u_planner (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .budget  (budget_ff),
      .ring    (ring_ff),
      .rd_data (rd_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .res     (res)
   );

   always_comb begin
      budget_in = budget_ff;
      ring_in   = ring_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BUDGET: budget_in = csr_data;
            CSR_RING:   ring_in   = csr_data[RING_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      layer_count_in = layer_count_ff;
      if (req_accept) begin
         if (req_word.is_last) begin
            layer_count_in = '0;
         end else if (!store_full) begin
            layer_count_in = layer_count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = res.done || (rsp_valid_ff && rsp_stall);
      rsp_word_in  = rsp_word_ff;
      if (res.done) begin
         rsp_word_in.pinned_count = res.pinned;
         rsp_word_in.slot_bytes   = res.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff      <= '0;
         ring_ff        <= MIN_RING;
         layer_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         budget_ff      <= budget_in;
         ring_ff        <= ring_in;
         layer_count_ff <= layer_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- src/prbp_checker.sv -----
// Port-level checks for the planner top level, bound in below.
// Depends on prbp_pkg and pin_and_ring_budget_planner_core.
module prbp_checker
   import prbp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_word_type         req_word,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_word_type         rsp_word
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a last word starts planning, so input must stall next cycle
   a_plan_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.is_last |=> req_stall)
      else $error("input not stalled after last word");

   // a new result only comes out of a plan in progress
   a_rsp_from_plan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a plan");

   // slot is never zero and pin count never exceeds the store
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.slot_bytes != '0 && rsp_word.pinned_count <= FULL_COUNT)
      else $error("result out of range");

endmodule

bind pin_and_ring_budget_planner_core prbp_checker u_prbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
